FILE: hdl/kabf_pkg.sv
package kabf_pkg;

    localparam int unsigned DataWidth  = 32;
    localparam int unsigned NoiseWidth = 31;
    localparam int unsigned DtWidth    = 16;
    localparam int unsigned CfgIdxWidth = 2;

    localparam logic [CfgIdxWidth-1:0] CFG_ANGLE_NOISE = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_BIAS_NOISE  = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_MEAS_NOISE  = 2'd2;

    localparam logic [NoiseWidth-1:0] ANGLE_NOISE_RESET = 31'd16777;
    localparam logic [NoiseWidth-1:0] BIAS_NOISE_RESET  = 31'd50332;
    localparam logic [NoiseWidth-1:0] MEAS_NOISE_RESET  = 31'd503316;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_FORCE  = 1'b1;

    // Datapath micro-operations, one per controller step
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,      // capture inputs
        OP_FORCE,     // angle <= measured angle
        OP_RATE,      // rate = sat(mr - bias)
        OP_ANG_PRED,  // ang += rs16(dt*rate)
        OP_T,         // t = rs16(dt*p11)
        OP_INNER,     // inner = t - p01 - p10 + q_angle
        OP_P00_PRED,  // p00 += rs16(dt*inner)
        OP_P01_PRED,  // p01 -= t ; p10 -= t
        OP_P11_PRED,  // p11 += rs16(q_bias*dt)
        OP_S,         // s = p00 + r
        OP_DIV0,      // start divide p00/s
        OP_DIV0_END,  // k0 <= quotient
        OP_DIV1,      // start divide p10/s
        OP_DIV1_END,  // k1 <= quotient
        OP_Y,         // y = sat(ma - ang)
        OP_ANG_COR,   // ang += rs24(k0*y)
        OP_BIAS_COR,  // bias += rs24(k1*y)
        OP_P00_COR,
        OP_P01_COR,
        OP_P10_COR,
        OP_P11_COR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
    } dp_status_t;

    function automatic logic signed [DataWidth-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] mx;
        logic signed [65:0] mn;
        begin
            mx = 66'sd2147483647;
            mn = -66'sd2147483648;
            if (v > mx)
                sat32 = 32'sh7FFFFFFF;
            else if (v < mn)
                sat32 = 32'sh80000000;
            else
                sat32 = v[DataWidth-1:0];
        end
    endfunction

endpackage

FILE: hdl/kabf_div.sv
// Signed restoring divider: quotient of (num << 24) / den, truncated toward zero
// and saturated to 32 bits. One quotient bit per cycle.
module kabf_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [kabf_pkg::DataWidth:0] num,
    input  logic signed [kabf_pkg::DataWidth+1:0] den,
    output logic                               busy,
    output logic signed [kabf_pkg::DataWidth-1:0] quot
);
    import kabf_pkg::*;

    localparam int unsigned NumBits = 58;  // |num| << 24 fits in 57 bits
    localparam int unsigned CntWidth = 6;

    logic [NumBits-1:0]   dividend_reg, dividend_next;
    logic [NumBits-1:0]   q_reg, q_next;
    logic [NumBits:0]     rem_reg, rem_next;
    logic [33:0]          den_mag_reg;
    logic                 neg_reg;
    logic                 busy_reg;
    logic [CntWidth-1:0]  cnt_reg;
    logic [NumBits:0]     trial;
    logic [NumBits:0]     shifted;
    logic [NumBits-1:0]   num_mag;
    logic [33:0]          den_mag;
    logic signed [65:0]   signed_q;

    assign num_mag = num[DataWidth] ? NumBits'(-num) << 24 : NumBits'(num) << 24;
    assign den_mag = den[DataWidth+1] ? 34'(-den) : 34'(den);
    assign shifted = {rem_reg[NumBits-1:0], dividend_reg[NumBits-1]};
    assign trial   = shifted - (NumBits+1)'(den_mag_reg);

    always_comb
    begin
        dividend_next = {dividend_reg[NumBits-2:0], 1'b0};
        if (!trial[NumBits])
        begin
            rem_next = trial;
            q_next   = {q_reg[NumBits-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted;
            q_next   = {q_reg[NumBits-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg     <= 1'b1;
            cnt_reg      <= CntWidth'(NumBits - 1);
            dividend_reg <= num_mag;
            rem_reg      <= '0;
            q_reg        <= '0;
            den_mag_reg  <= den_mag;
            neg_reg      <= num[DataWidth] ^ den[DataWidth+1];
        end
        else if (busy_reg)
        begin
            dividend_reg <= dividend_next;
            rem_reg      <= rem_next;
            q_reg        <= q_next;
            cnt_reg      <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
        end
    end

    assign signed_q = neg_reg ? -$signed({8'd0, q_reg}) : $signed({8'd0, q_reg});
    assign quot     = sat32(signed_q);
    assign busy     = busy_reg;

endmodule

FILE: hdl/kabf_datapath.sv
module kabf_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  kabf_pkg::dp_cmd_t                     cmd,
    output kabf_pkg::dp_status_t                  status,
    input  logic signed [kabf_pkg::DataWidth-1:0] measured_angle,
    input  logic signed [kabf_pkg::DataWidth-1:0] measured_rate,
    input  logic [kabf_pkg::DtWidth-1:0]          time_step,
    input  logic [kabf_pkg::NoiseWidth-1:0]       q_angle,
    input  logic [kabf_pkg::NoiseWidth-1:0]       q_bias,
    input  logic [kabf_pkg::NoiseWidth-1:0]       r_meas,
    output logic signed [kabf_pkg::DataWidth-1:0] angle_out,
    output logic signed [kabf_pkg::DataWidth-1:0] bias_out
);
    import kabf_pkg::*;

    logic signed [DataWidth-1:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [DataWidth-1:0] ma_reg, mr_reg, rate_reg, t_reg, k0_reg, k1_reg, y_reg;
    logic signed [DataWidth-1:0] old00_reg, old01_reg;
    logic [DtWidth-1:0]          dt_reg;
    logic signed [34:0]          inner_reg;
    logic signed [33:0]          s_reg;
    logic signed [DataWidth-1:0] quot;
    logic                        div_start;
    logic signed [DataWidth:0]   div_num;

    // Shared multiplier: one product per step
    logic signed [DataWidth+1:0] mul_a;
    logic signed [DataWidth+1:0] mul_b;
    logic signed [65:0]          prod;
    logic [4:0]                  shamt;
    logic signed [65:0]          rounded;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        shamt = 5'd16;
        unique case (cmd.op)
            OP_ANG_PRED: begin mul_a = 34'(rate_reg); mul_b = 34'($signed({1'b0, dt_reg})); end
            OP_T:        begin mul_a = 34'(p11_reg);  mul_b = 34'($signed({1'b0, dt_reg})); end
            OP_P00_PRED: begin mul_a = inner_reg[33:0]; mul_b = 34'($signed({1'b0, dt_reg})); end
            OP_P11_PRED: begin mul_a = 34'($signed({1'b0, q_bias})); mul_b = 34'($signed({1'b0, dt_reg})); end
            OP_ANG_COR:  begin mul_a = 34'(k0_reg); mul_b = 34'(y_reg); shamt = 5'd24; end
            OP_BIAS_COR: begin mul_a = 34'(k1_reg); mul_b = 34'(y_reg); shamt = 5'd24; end
            OP_P00_COR:  begin mul_a = 34'(k0_reg); mul_b = 34'(old00_reg); shamt = 5'd24; end
            OP_P01_COR:  begin mul_a = 34'(k0_reg); mul_b = 34'(old01_reg); shamt = 5'd24; end
            OP_P10_COR:  begin mul_a = 34'(k1_reg); mul_b = 34'(old00_reg); shamt = 5'd24; end
            OP_P11_COR:  begin mul_a = 34'(k1_reg); mul_b = 34'(old01_reg); shamt = 5'd24; end
            default:     begin mul_a = '0; mul_b = '0; end
        endcase
        prod    = mul_a * mul_b;
        rounded = (prod + (66'sd1 <<< (shamt - 5'd1))) >>> shamt;
    end

    assign div_start = (cmd.op == OP_DIV0) || (cmd.op == OP_DIV1);
    assign div_num   = (cmd.op == OP_DIV0) ? 33'(p00_reg) : 33'(p10_reg);

    kabf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_reg),
        .busy  (status.div_busy),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_reg  <= '0;
            bias_reg <= '0;
            p00_reg  <= '0;
            p01_reg  <= '0;
            p10_reg  <= '0;
            p11_reg  <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    ma_reg <= measured_angle;
                    mr_reg <= measured_rate;
                    dt_reg <= time_step;
                end
                OP_FORCE:    ang_reg  <= ma_reg;
                OP_RATE:     rate_reg <= sat32(66'(mr_reg) - 66'(bias_reg));
                OP_ANG_PRED: ang_reg  <= sat32(66'(ang_reg) + rounded);
                OP_T:        t_reg    <= rounded[DataWidth-1:0];
                OP_INNER:    inner_reg <= 35'(t_reg) - 35'(p01_reg) - 35'(p10_reg)
                                          + 35'($signed({1'b0, q_angle}));
                OP_P00_PRED: p00_reg  <= sat32(66'(p00_reg) + rounded);
                OP_P01_PRED:
                begin
                    p01_reg <= sat32(66'(p01_reg) - 66'(t_reg));
                    p10_reg <= sat32(66'(p10_reg) - 66'(t_reg));
                end
                OP_P11_PRED: p11_reg  <= sat32(66'(p11_reg) + rounded);
                OP_S:        s_reg    <= 34'(p00_reg) + 34'($signed({1'b0, r_meas}));
                OP_DIV0_END: k0_reg   <= (s_reg == '0) ? '0 : quot;
                OP_DIV1_END: k1_reg   <= (s_reg == '0) ? '0 : quot;
                OP_Y:
                begin
                    y_reg     <= sat32(66'(ma_reg) - 66'(ang_reg));
                    old00_reg <= p00_reg;
                    old01_reg <= p01_reg;
                end
                OP_ANG_COR:  ang_reg  <= sat32(66'(ang_reg) + rounded);
                OP_BIAS_COR: bias_reg <= sat32(66'(bias_reg) + rounded);
                OP_P00_COR:  p00_reg  <= sat32(66'(p00_reg) - rounded);
                OP_P01_COR:  p01_reg  <= sat32(66'(p01_reg) - rounded);
                OP_P10_COR:  p10_reg  <= sat32(66'(p10_reg) - rounded);
                OP_P11_COR:  p11_reg  <= sat32(66'(p11_reg) - rounded);
                default:     ;
            endcase
        end
    end

    assign angle_out = ang_reg;
    assign bias_out  = bias_reg;

endmodule

FILE: hdl/kabf_ctrl.sv
module kabf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    output logic                 out_valid,
    input  logic                 out_ready,
    output kabf_pkg::dp_cmd_t    cmd,
    input  kabf_pkg::dp_status_t status
);
    import kabf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_DONE
    } state_t;

    state_t state_reg;
    dp_op_t op_reg;
    logic   out_valid_reg;
    logic   cmd_reg;
    logic   div1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_NOP;
            out_valid_reg <= 1'b0;
            cmd_reg       <= CMD_UPDATE;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && !out_valid_reg)
                    begin
                        cmd_reg   <= command;
                        op_reg    <= OP_LOAD;
                        state_reg <= ST_RUN;
                    end
                    else
                        op_reg <= OP_NOP;
                end
                ST_RUN:
                begin
                    priority if (op_reg == OP_LOAD)
                        op_reg <= (cmd_reg == CMD_FORCE) ? OP_FORCE : OP_RATE;
                    else if (op_reg == OP_FORCE || op_reg == OP_P11_COR)
                    begin
                        op_reg    <= OP_NOP;
                        state_reg <= ST_DONE;
                    end
                    else if (op_reg == OP_DIV0 || op_reg == OP_DIV1)
                    begin
                        op_reg    <= OP_NOP;
                        state_reg <= ST_WAIT;
                    end
                    else
                        op_reg <= dp_op_t'(op_reg + 5'd1);
                end
                ST_WAIT:
                begin
                    if (!status.div_busy)
                    begin
                        op_reg    <= (!div1_reg) ? OP_DIV0_END : OP_DIV1_END;
                        state_reg <= ST_RUN;
                    end
                end
                ST_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Track which division is in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div1_reg <= 1'b0;
        else if (op_reg == OP_DIV0)
            div1_reg <= 1'b0;
        else if (op_reg == OP_DIV1)
            div1_reg <= 1'b1;
    end

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign cmd.op    = op_reg;

`ifndef SYNTHESIS
    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> out_valid)
        else $error("result not raised");
    a_wait_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (op_reg == OP_DIV0) |=> (state_reg == ST_WAIT))
        else $error("divider not awaited");
`endif

endmodule

FILE: hdl/kalman_angle_bias_filter_top.sv
// Two-state Kalman filter (angle and gyro bias) in fixed point. One item is
// taken at a time: an update item runs a sequence of 20 datapath steps on one
// shared 34x34 multiplier, two of which start a division for a gain; each
// division holds the sequence until all 58 quotient bits are produced and the
// divider is seen to finish. The result is offered once the last step is done,
// and the next input is taken no sooner than the cycle after the result
// transfer; a force-angle item offers its result after its LOAD and FORCE steps.
// The divider produces one quotient bit per cycle. Each item returns one
// transfer of filtered angle and bias. Write noise registers while idle.
module kalman_angle_bias_filter_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [kabf_pkg::CfgIdxWidth-1:0]      cfg_index,
    input  logic [kabf_pkg::NoiseWidth-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  command,
    input  logic signed [kabf_pkg::DataWidth-1:0] measured_angle,
    input  logic signed [kabf_pkg::DataWidth-1:0] measured_rate,
    input  logic [kabf_pkg::DtWidth-1:0]          time_step,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [kabf_pkg::DataWidth-1:0] filtered_angle,
    output logic signed [kabf_pkg::DataWidth-1:0] rate_bias
);
    import kabf_pkg::*;

    logic [NoiseWidth-1:0] q_angle_reg, q_bias_reg, r_meas_reg;
    dp_cmd_t               cmd;
    dp_status_t            status;

    // Noise registers; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_angle_reg <= ANGLE_NOISE_RESET;
            q_bias_reg  <= BIAS_NOISE_RESET;
            r_meas_reg  <= MEAS_NOISE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ANGLE_NOISE)
                q_angle_reg <= cfg_data;
            if (cfg_index == CFG_BIAS_NOISE)
                q_bias_reg <= cfg_data;
            if (cfg_index == CFG_MEAS_NOISE)
                r_meas_reg <= cfg_data;
        end
    end

    kabf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Inputs are captured on the cycle after the transfer, while still held
    // stable only if valid persists; capture happens in the LOAD step which
    // follows acceptance, so latch them here at the transfer.
    logic signed [DataWidth-1:0] ma_hold_reg, mr_hold_reg;
    logic [DtWidth-1:0]          dt_hold_reg;
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ma_hold_reg <= measured_angle;
            mr_hold_reg <= measured_rate;
            dt_hold_reg <= time_step;
        end
    end

    kabf_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .measured_angle (ma_hold_reg),
        .measured_rate  (mr_hold_reg),
        .time_step      (dt_hold_reg),
        .q_angle        (q_angle_reg),
        .q_bias         (q_bias_reg),
        .r_meas         (r_meas_reg),
        .angle_out      (filtered_angle),
        .bias_out       (rate_bias)
    );

endmodule
